/* sv/dss_pkg.sv */
// dss_pkg: shared constants for the donor slot selector.
// Field widths, default table depth and opcode codes. No dependencies.
`timescale 1ns / 1ps

package dss_pkg;

  // default number of donor slots
  localparam int unsigned SLOTS_DEF = 64;

  // fixed field widths
  localparam int unsigned DS_W      = 32;
  localparam int unsigned START_W   = 6;
  localparam int unsigned SLOT_W    = 6;

  // opcode codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

/* sv/dss_req_if.sv */
// dss_req_if: request channel of the donor slot selector (load or query item).
// Depends on dss_pkg for the field widths.
`timescale 1ns / 1ps

interface dss_req_if import dss_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               opcode;
  logic               donor_valid;
  logic [DS_W-1:0]    dataset_id;
  logic [START_W-1:0] start_slot;
  logic               last_entry;

  modport source (
    output valid, opcode, donor_valid, dataset_id, start_slot, last_entry,
    input  ready
  );

  modport sink (
    input  valid, opcode, donor_valid, dataset_id, start_slot, last_entry,
    output ready
  );

endinterface

/* sv/dss_rsp_if.sv */
// dss_rsp_if: result channel of the donor slot selector (one item per query).
// Depends on dss_pkg for the field widths.
`timescale 1ns / 1ps

interface dss_rsp_if import dss_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] sel_slot;

  modport source (
    output valid, found, sel_slot,
    input  ready
  );

  modport sink (
    input  valid, found, sel_slot,
    output ready
  );

endinterface

/* sv/donor_slot_selector_top.sv */
// donor_slot_selector_top: donor table with circular next-valid and
// next-different lookup. Depends on dss_pkg, dss_req_if, dss_rsp_if, dss_mem.
//
//  channel | modport       | direction | payload
//  --------+---------------+-----------+----------------------------------------------
//  req_i   | dss_req_if    | in        | opcode, donor_valid, dataset_id, start_slot,
//          | .sink         |           | last_entry
//  rsp_o   | dss_rsp_if    | out       | found, sel_slot (one item per query)
//
//  A query reads the next-valid entry, then the entry and dataset of that slot,
//  then registers the result; the second table read depends on the first.
//  A load with last_entry starts a rebuild: two backward walks over the entry
//  memory, one entry per cycle.
//  Reset clears control only; table memories hold nothing valid until rebuilt.
//  A query that finishes while the result register is still full waits in ST_QDS;
//  no loads or queries are taken while it waits.
`timescale 1ns / 1ps

module donor_slot_selector_top import dss_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dss_req_if.sink    req_i,
  dss_rsp_if.source  rsp_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned NW = $clog2(SLOTS + 1);
  localparam int unsigned SW = (NW > START_W) ? NW : START_W;
  localparam int unsigned AW_D = 1 + DS_W;
  localparam int unsigned BW_D = 2 * NW;
  localparam logic [NW-1:0] NONE = NW'(SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_QNV  = 4'b0010,
    ST_QDS  = 4'b0100,
    ST_WALK = 4'b1000
  } state_e;

  // control registers
  state_e          state_q;
  logic [NW-1:0]   lp_q;
  logic [NW-1:0]   ts_q;
  logic            any_q;
  logic [NW-1:0]   rb_size_q;
  logic [IW-1:0]   rb_last_q;
  logic [IW-1:0]   rd_ptr_q;
  logic            rd_act_q;
  logic            p_vld_q;
  logic [IW-1:0]   p_idx_q;
  logic            lap_q;
  logic            q_ok_q;
  logic            out_vld_q;

  // payload registers
  logic [IW-1:0]     first_q;
  logic [DS_W-1:0]   first_ds_q;
  logic [NW-1:0]     nx_slot_q;
  logic [DS_W-1:0]   nx_ds_q;
  logic [NW-1:0]     nx_no_q;
  logic [DS_W-1:0]   q_ds_q;
  logic [IW-1:0]     q_first_q;
  logic              out_found_q;
  logic [SLOT_W-1:0] out_slot_q;

  // memory ports
  logic            a_we, a_re;
  logic [IW-1:0]   a_waddr, a_raddr;
  logic [AW_D-1:0] a_wdata, a_rdata;
  logic            b_we, b_re;
  logic [IW-1:0]   b_waddr, b_raddr;
  logic [BW_D-1:0] b_wdata, b_rdata;

  // entry memory: {valid, dataset}
  dss_mem #(.WIDTH(AW_D), .DEPTH(SLOTS)) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  // lookup memory: {next valid, next different}
  dss_mem #(.WIDTH(BW_D), .DEPTH(SLOTS)) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // handshake decode
  logic acc, is_load, is_query, out_free;
  assign req_i.ready = (state_q == ST_IDLE);
  assign acc      = req_i.valid && req_i.ready;
  assign is_load  = acc && (req_i.opcode == OP_LOAD);
  assign is_query = acc && (req_i.opcode == OP_QUERY);
  assign out_free = !out_vld_q || rsp_o.ready;

  // load bookkeeping: pointer, first valid slot of the sequence
  logic            lp_full, seq_start, any_base, load_vld, new_first, any_d;
  logic [NW-1:0]   lp_inc, lp_dec;
  logic [IW-1:0]   first_d;
  logic [DS_W-1:0] first_ds_d;

  always_comb begin
    lp_full    = (lp_q == NONE);
    seq_start  = (lp_q == '0);
    lp_inc     = lp_full ? lp_q : lp_q + 1'b1;
    lp_dec     = lp_inc - 1'b1;
    any_base   = seq_start ? 1'b0 : any_q;
    load_vld   = is_load && !lp_full && req_i.donor_valid;
    new_first  = load_vld && !any_base;
    any_d      = any_base || load_vld;
    first_d    = new_first ? lp_q[IW-1:0] : first_q;
    first_ds_d = new_first ? req_i.dataset_id : first_ds_q;
  end

  // query range check
  logic [SW-1:0] start_ext, ts_ext;
  logic          in_range;
  assign start_ext = SW'(req_i.start_slot);
  assign ts_ext    = SW'(ts_q);
  assign in_range  = (start_ext < ts_ext);

  // walk step: one entry per cycle, backward in slot order
  logic            e_vld;
  logic [DS_W-1:0] e_ds;
  logic [NW-1:0]   e_no;
  logic [NW-1:0]   b_nv, b_no;
  assign e_vld = a_rdata[DS_W];
  assign e_ds  = a_rdata[DS_W-1:0];
  assign e_no  = (e_ds != nx_ds_q) ? nx_slot_q : nx_no_q;
  assign b_nv  = b_rdata[BW_D-1:NW];
  assign b_no  = b_rdata[NW-1:0];

  logic qnv_hit;
  assign qnv_hit = q_ok_q && (b_nv != NONE);

  // memory port selection
  always_comb begin
    a_we    = is_load && !lp_full;
    a_waddr = lp_q[IW-1:0];
    a_wdata = {req_i.donor_valid, req_i.dataset_id};
    a_re    = 1'b0;
    a_raddr = rd_ptr_q;
    b_re    = 1'b0;
    b_raddr = start_ext[IW-1:0];
    b_we    = (state_q == ST_WALK) && p_vld_q;
    b_waddr = p_idx_q;
    b_wdata = e_vld ? {NW'(p_idx_q), e_no} : {nx_slot_q, NONE};
    case (state_q)
      ST_IDLE: begin
        b_re = is_query && in_range;
      end
      ST_QNV: begin
        a_re    = qnv_hit;
        a_raddr = b_nv[IW-1:0];
        b_re    = qnv_hit;
        b_raddr = b_nv[IW-1:0];
      end
      ST_WALK: begin
        a_re = rd_act_q;
      end
      default: begin
      end
    endcase
  end

  // query result
  logic [NW-1:0]     pick;
  logic [SW-1:0]     pick_ext;
  logic              pick_found;
  logic [SLOT_W-1:0] pick_slot;
  always_comb begin
    if (!q_ok_q) begin
      pick = NONE;
    end else if (e_ds == q_ds_q) begin
      pick = b_no;
    end else begin
      pick = NW'(q_first_q);
    end
    pick_ext   = SW'(pick);
    pick_found = (pick != NONE);
    pick_slot  = pick_found ? pick_ext[SLOT_W-1:0] : '0;
  end

  // result valid: set when a query finishes, drop once delivered
  logic out_vld_d;
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
    if ((state_q == ST_QDS) && out_free) begin
      out_vld_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lp_q      <= '0;
      ts_q      <= '0;
      any_q     <= 1'b0;
      rb_size_q <= '0;
      rb_last_q <= '0;
      rd_ptr_q  <= '0;
      rd_act_q  <= 1'b0;
      p_vld_q   <= 1'b0;
      p_idx_q   <= '0;
      lap_q     <= 1'b0;
      q_ok_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      case (state_q)
        ST_IDLE: begin
          if (is_load) begin
            any_q <= any_d;
            // drop the table on the first load and during the rebuild
            if (seq_start || req_i.last_entry) begin
              ts_q <= '0;
            end
            if (req_i.last_entry) begin
              lp_q      <= '0;
              rb_size_q <= lp_inc;
              rb_last_q <= lp_dec[IW-1:0];
              rd_ptr_q  <= lp_dec[IW-1:0];
              rd_act_q  <= 1'b1;
              p_vld_q   <= 1'b0;
              lap_q     <= 1'b0;
              state_q   <= ST_WALK;
            end else begin
              lp_q <= lp_inc;
            end
          end else if (is_query) begin
            q_ok_q  <= in_range;
            state_q <= ST_QNV;
          end
        end
        ST_QNV: begin
          q_ok_q  <= qnv_hit;
          state_q <= ST_QDS;
        end
        ST_QDS: begin
          // hold here until the result register is free
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_WALK: begin
          // advance read pointer
          if (rd_act_q) begin
            p_vld_q <= 1'b1;
            p_idx_q <= rd_ptr_q;
            if (rd_ptr_q == '0) begin
              rd_act_q <= 1'b0;
            end else begin
              rd_ptr_q <= rd_ptr_q - 1'b1;
            end
          end else begin
            p_vld_q <= 1'b0;
          end
          // end of a lap: restart once, then publish the table
          if (p_vld_q && (p_idx_q == '0)) begin
            if (!lap_q) begin
              lap_q    <= 1'b1;
              rd_act_q <= 1'b1;
              rd_ptr_q <= rb_last_q;
            end else begin
              ts_q    <= rb_size_q;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload state
  always_ff @(posedge clk_i) begin
    if (is_load) begin
      first_q    <= first_d;
      first_ds_q <= first_ds_d;
      if (req_i.last_entry) begin
        // seed the walk with the wrap-around successor
        nx_slot_q <= any_d ? NW'(first_d) : NONE;
        nx_ds_q   <= first_ds_d;
        nx_no_q   <= NONE;
      end
    end
    if (is_query) begin
      q_ds_q <= req_i.dataset_id;
    end
    if (state_q == ST_QNV) begin
      q_first_q <= b_nv[IW-1:0];
    end
    if ((state_q == ST_WALK) && p_vld_q && e_vld) begin
      nx_slot_q <= NW'(p_idx_q);
      nx_ds_q   <= e_ds;
      nx_no_q   <= e_no;
    end
    if ((state_q == ST_QDS) && out_free) begin
      out_found_q <= pick_found;
      out_slot_q  <= pick_slot;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.sel_slot = out_slot_q;

endmodule

/* sv/dss_mem.sv */
// dss_mem: simple dual-port synchronous RAM, one write and one read port,
// read data registered. No package dependencies.
`timescale 1ns / 1ps

module dss_mem #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/dss_checker.sv */
// dss_checker: port-level assertions for donor_slot_selector_top, bound in below.
// Depends on dss_pkg for opcode codes and field widths.
`timescale 1ns / 1ps

module dss_checker import dss_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_opcode_i,
  input logic              in_last_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_found_i,
  input logic [SLOT_W-1:0] out_slot_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_found_i) && $stable(out_slot_i))
    else $error("result changed while stalled");

  // empty answer carries slot zero
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_slot_i == '0)
    else $error("slot not zero on empty answer");

  // last load starts the rebuild
  a_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_opcode_i == OP_LOAD) && in_last_i |=> !in_ready_i)
    else $error("no rebuild after last load");

  // plain load keeps the input open
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_opcode_i == OP_LOAD) && !in_last_i |=> in_ready_i)
    else $error("input closed after plain load");

  // query occupies the table for its lookups
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_opcode_i == OP_QUERY) |=> !in_ready_i ##1 !in_ready_i)
    else $error("input open during query lookup");

endmodule

bind donor_slot_selector_top dss_checker u_dss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_opcode_i (req_i.opcode),
  .in_last_i   (req_i.last_entry),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_found_i (rsp_o.found),
  .out_slot_i  (rsp_o.sel_slot)
);

/* sim/testbench.sv */
// testbench: self-checking bench for donor_slot_selector_top, driven through the
// request and result interfaces. Depends on dss_pkg, dss_req_if, dss_rsp_if and the RTL.
`timescale 1ns / 1ps

module testbench;
  import dss_pkg::*;

  localparam int unsigned SLOTS   = SLOTS_DEF;
  localparam int unsigned NO_SLOT = SLOTS;

  typedef struct packed {
    logic               opcode;
    logic               donor_valid;
    logic [DS_W-1:0]    dataset_id;
    logic [START_W-1:0] start_slot;
    logic               last_entry;
  } dss_item_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] sel_slot;
  } dss_answer_t;

  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  dss_req_if req_if ();
  dss_rsp_if rsp_if ();

  donor_slot_selector_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Predicted donor table: loaded entries and the two lookup tables
  bit              slot_has_label   [SLOTS] = '{default: 0};
  logic [DS_W-1:0] slot_dataset     [SLOTS] = '{default: '0};
  int unsigned     first_valid_from [SLOTS] = '{default: 0};
  int unsigned     next_other_of    [SLOTS] = '{default: 0};
  int unsigned     fill_ptr      = 0;
  int unsigned     covered_slots = 0;

  dss_answer_t pending_answers [$];

  int unsigned errors          = 0;
  int unsigned items_sent      = 0;
  int unsigned loads_sent      = 0;
  int unsigned queries_sent    = 0;
  int unsigned rebuilds        = 0;
  int unsigned answers_checked = 0;
  int unsigned answers_found   = 0;

  int unsigned burst_left   = 0;
  int unsigned rsp_hold_req = 0;
  int unsigned hold_left    = 0;
  int unsigned mode_left    = 0;
  rx_mode_e    rx_mode      = RX_STREAM;

  // Recompute both lookup tables over the first size entries
  function automatic void rebuild_lookup(input int unsigned size);
    int unsigned members [$];
    int unsigned i, k, cand, first_v;
    for (i = 0; i < size; i++) begin
      first_valid_from[i] = NO_SLOT;
      next_other_of[i]    = NO_SLOT;
      if (slot_has_label[i]) members = {members, i};
    end
    covered_slots = size;
    if (members.size() == 0) return;
    // walk backward so each slot sees the nearest labeled slot at or after it
    first_v = members[0];
    for (i = size; i > 0; i--) begin
      if (slot_has_label[i-1]) first_v = i - 1;
      first_valid_from[i-1] = first_v;
    end
    // first labeled slot in circular order with a different dataset
    for (i = 0; i < members.size(); i++) begin
      for (k = 1; k < members.size(); k++) begin
        cand = members[(i + k) % members.size()];
        if (slot_dataset[cand] != slot_dataset[members[i]]) begin
          next_other_of[members[i]] = cand;
          break;
        end
      end
    end
  endfunction

  // Advance the predicted state by one accepted item; queue the answer of a query
  function automatic void apply_item(input dss_item_t it);
    dss_answer_t ans;
    int unsigned first_v, pick;
    if (it.opcode == OP_LOAD) begin
      loads_sent++;
      if (fill_ptr == 0) covered_slots = 0;
      if (fill_ptr < SLOTS) begin
        slot_has_label[fill_ptr] = it.donor_valid;
        slot_dataset[fill_ptr]   = it.dataset_id;
        fill_ptr++;
      end
      if (it.last_entry) begin
        rebuild_lookup(fill_ptr);
        fill_ptr = 0;
        rebuilds++;
      end
    end else begin
      queries_sent++;
      pick = NO_SLOT;
      if (it.start_slot < covered_slots) begin
        first_v = first_valid_from[it.start_slot];
        if (first_v != NO_SLOT)
          pick = (slot_dataset[first_v] == it.dataset_id) ? next_other_of[first_v] : first_v;
      end
      ans.found    = (pick != NO_SLOT);
      ans.sel_slot = ans.found ? SLOT_W'(pick) : '0;
      pending_answers = {pending_answers, ans};
    end
  endfunction

  function automatic dss_item_t mk_load(input logic lbl, input logic [DS_W-1:0] ds,
                                        input logic last);
    dss_item_t it;
    it.opcode      = OP_LOAD;
    it.donor_valid = lbl;
    it.dataset_id  = ds;
    it.start_slot  = START_W'($urandom);
    it.last_entry  = last;
    return it;
  endfunction

  function automatic dss_item_t mk_query(input int unsigned start, input logic [DS_W-1:0] ds);
    dss_item_t it;
    it.opcode      = OP_QUERY;
    it.donor_valid = 1'($urandom_range(1, 0));
    it.dataset_id  = ds;
    it.start_slot  = START_W'(start);
    it.last_entry  = 1'($urandom_range(1, 0));
    return it;
  endfunction

  // Offer one item in bursts with random gaps; predict once it is accepted
  task automatic send_item(input dss_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 1);
      gap = $urandom_range(6, 0);
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.opcode      <= it.opcode;
    req_if.donor_valid <= it.donor_valid;
    req_if.dataset_id  <= it.dataset_id;
    req_if.start_slot  <= it.start_slot;
    req_if.last_entry  <= it.last_entry;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    apply_item(it);
    items_sent++;
  endtask

  // Drop valid after the last item of a test
  task automatic finish_burst();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Result side: long hold on request, else a stall pattern that changes now and then
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (rsp_hold_req != 0) begin
      hold_left    = rsp_hold_req - 1;
      rsp_hold_req = 0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(2, 0))
          0:       rx_mode = RX_STREAM;
          1:       rx_mode = RX_RANDOM;
          default: rx_mode = RX_SPARSE;
        endcase
        mode_left = $urandom_range(60, 10);
      end
      mode_left--;
      case (rx_mode)
        RX_STREAM: rsp_if.ready <= 1'b1;
        RX_RANDOM: rsp_if.ready <= 1'($urandom_range(1, 0));
        default:   rsp_if.ready <= ($urandom_range(3, 0) == 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest predicted answer
  always @(posedge clk_i) begin : check_results
    dss_answer_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: found %0b sel_slot %0d", rsp_if.found, rsp_if.sel_slot);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (want.found) answers_found++;
        if (rsp_if.found !== want.found) begin
          $error("found mismatch: expected %0b, got %0b", want.found, rsp_if.found);
          errors++;
        end
        if (rsp_if.sel_slot !== want.sel_slot) begin
          $error("sel_slot mismatch: expected %0d, got %0d",
                 want.sel_slot, rsp_if.sel_slot);
          errors++;
        end
      end
    end
  end

  // Queries before any table exists, with the ignored flags set
  task automatic test_no_table();
    dss_item_t it;
    send_item(mk_query(0, 32'h0000_0000));
    it = mk_query(63, 32'hFFFF_FFFF);
    it.donor_valid = 1'b1;
    it.last_entry  = 1'b1;
    send_item(it);
    finish_burst();
  endtask

  // Small hand-built tables: mixed datasets, no labeled slot, one dataset, one slot
  task automatic test_small_tables();
    send_item(mk_load(1'b1, 32'h0000_0000, 1'b0));
    send_item(mk_query(0, 32'h0000_0000));          // table dropped while loading
    send_item(mk_load(1'b0, 32'hFFFF_FFFF, 1'b0));
    send_item(mk_load(1'b1, 32'hFFFF_FFFF, 1'b0));
    send_item(mk_load(1'b1, 32'h0000_0000, 1'b1));
    send_item(mk_query(0, 32'h0000_0000));
    send_item(mk_query(1, 32'hFFFF_FFFF));
    send_item(mk_query(3, 32'h0000_0007));
    send_item(mk_query(3, 32'h0000_0000));
    send_item(mk_query(4, 32'h0000_0000));          // start past the table
    send_item(mk_query(63, 32'h0000_0000));
    // no labeled slot at all
    send_item(mk_load(1'b0, 32'h0000_0005, 1'b0));
    send_item(mk_load(1'b0, 32'h0000_0005, 1'b1));
    send_item(mk_query(0, 32'h0000_0005));
    send_item(mk_query(1, 32'h0000_0009));
    // every labeled slot in one dataset
    send_item(mk_load(1'b1, 32'h1234_5678, 1'b0));
    send_item(mk_load(1'b1, 32'h1234_5678, 1'b0));
    send_item(mk_load(1'b1, 32'h1234_5678, 1'b1));
    send_item(mk_query(2, 32'h1234_5678));
    send_item(mk_query(2, 32'h8765_4321));
    send_item(mk_query(0, 32'h1234_5678));
    // single-entry table
    send_item(mk_load(1'b1, 32'hFFFF_FFFF, 1'b1));
    send_item(mk_query(0, 32'h0000_0000));
    send_item(mk_query(0, 32'hFFFF_FFFF));
    finish_burst();
  endtask

  // More loads than slots: the extra entries drop, the rebuild covers the full table
  task automatic test_overflow();
    logic [DS_W-1:0] pool [3];
    int unsigned i;
    foreach (pool[j]) pool[j] = $urandom;
    for (i = 0; i < 70; i++)
      send_item(mk_load($urandom_range(3, 0) != 0, pool[$urandom_range(2, 0)], i == 69));
    send_item(mk_query(63, pool[0]));
    send_item(mk_query(0, pool[1]));
    for (i = 0; i < 20; i++)
      send_item(mk_query($urandom_range(63, 0), pool[$urandom_range(2, 0)]));
    finish_burst();
  endtask

  // Hold the result side for a long stretch while queries keep coming
  task automatic test_result_backpressure();
    logic [DS_W-1:0] pool [2];
    int unsigned i;
    foreach (pool[j]) pool[j] = $urandom;
    for (i = 0; i < 8; i++)
      send_item(mk_load(1'($urandom_range(1, 0)), pool[$urandom_range(1, 0)], i == 7));
    rsp_hold_req = 300;
    for (i = 0; i < 24; i++)
      send_item(mk_query($urandom_range(9, 0), pool[$urandom_range(1, 0)]));
    finish_burst();
  endtask

  // Load sequences with random content, then queries; some noise and cut sequences
  task automatic test_random_sequences(input int unsigned target);
    logic [DS_W-1:0] pool [4];
    int unsigned n, n_ds, lbl_pct, n_q, i, roll, span;
    logic [63:0] raw_bits;
    dss_item_t it;
    while (items_sent < target) begin
      roll = $urandom_range(99, 0);
      if (roll < 70)      n = $urandom_range(12, 1);
      else if (roll < 90) n = $urandom_range(63, 13);
      else if (roll < 97) n = SLOTS;
      else                n = $urandom_range(SLOTS + 6, SLOTS + 1);
      n_ds = $urandom_range(4, 1);
      foreach (pool[j]) begin
        case ($urandom_range(9, 0))
          0:       pool[j] = '0;
          1:       pool[j] = '1;
          default: pool[j] = $urandom;
        endcase
      end
      case ($urandom_range(3, 0))
        0:       lbl_pct = 100;
        1:       lbl_pct = 60;
        2:       lbl_pct = 15;
        default: lbl_pct = ($urandom_range(4, 0) == 0) ? 0 : 80;
      endcase
      for (i = 0; i < n; i++) begin
        send_item(mk_load($urandom_range(99, 0) < lbl_pct, pool[$urandom_range(n_ds - 1, 0)],
                          i == n - 1));
        if ($urandom_range(99, 0) < 4)
          send_item(mk_query($urandom_range(63, 0), pool[0]));
      end
      span = (n < SLOTS) ? n : SLOTS;
      n_q = $urandom_range(15, 3);
      for (i = 0; i < n_q; i++) begin
        if ($urandom_range(99, 0) < 70)
          it = mk_query($urandom_range(span - 1, 0), pool[$urandom_range(n_ds - 1, 0)]);
        else
          it = mk_query($urandom_range(63, 0), $urandom);
        send_item(it);
      end
      // stray item: may leave a cut-short load sequence behind
      if ($urandom_range(99, 0) < 10) begin
        raw_bits = {$urandom, $urandom};
        it = raw_bits[$bits(dss_item_t)-1:0];
        send_item(it);
      end
      if ($urandom_range(3, 0) == 0) finish_burst();
    end
    finish_burst();
  endtask

  initial begin
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_LOAD;
    req_if.donor_valid = 1'b0;
    req_if.dataset_id  = '0;
    req_if.start_slot  = '0;
    req_if.last_entry  = 1'b0;
    rsp_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_no_table();
    test_small_tables();
    test_overflow();
    test_result_backpressure();
    test_random_sequences(550);

    // drain, then leave room for a full rebuild to settle
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 40) @(posedge clk_i);

    $display("Sent %0d items: %0d loads, %0d queries, %0d table rebuilds.",
             items_sent, loads_sent, queries_sent, rebuilds);
    $display("Checked %0d answers, %0d with a donor slot, %0d errors.",
             answers_checked, answers_found, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("Timeout with %0d answers still pending.", pending_answers.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
